// File: design/fpsc_pkg.sv
// Shared types, constants and saturation helpers for the filtered PID speed controller.
package fpsc_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned SumW  = 48;
    localparam int unsigned CoefW = 17;
    localparam int unsigned OpW   = 33;
    localparam int unsigned ProdW = 2 * OpW;
    localparam int unsigned AccW  = ProdW;
    localparam int unsigned IdxW  = 2;

    localparam logic signed [DataW-1:0] GainPReset = 32'sd655;
    localparam logic signed [DataW-1:0] GainIReset = 32'sd0;
    localparam logic signed [DataW-1:0] GainDReset = 32'sd0;
    localparam logic signed [DataW-1:0] DefaultKp  = 32'sd655;
    localparam logic [CoefW-1:0]        CoefReset  = 17'd58982;
    localparam logic [CoefW-1:0]        CoefOne    = 17'd65536;
    localparam logic signed [AccW-1:0]  RoundHalf  = AccW'(32768);

    typedef enum logic [IdxW-1:0] {
        REG_GAIN_P = 2'd0,
        REG_GAIN_I = 2'd1,
        REG_GAIN_D = 2'd2,
        REG_COEF   = 2'd3
    } t_reg_idx;

    // How a product is folded into the accumulator in the cycle after it is formed.
    typedef enum logic [1:0] {
        TAG_NONE = 2'd0,
        TAG_RAW  = 2'd1,
        TAG_RND  = 2'd2
    } t_tag;

    typedef enum logic [2:0] {
        SEL_FILT_NEW = 3'd0,
        SEL_FILT_OLD = 3'd1,
        SEL_P        = 3'd2,
        SEL_I_HI     = 3'd3,
        SEL_I_LO     = 3'd4,
        SEL_D        = 3'd5
    } t_mul_sel;

    typedef struct packed {
        t_mul_sel mul_sel;
        t_tag     tag;
        logic     acc_clr;
        logic     ld_filt;
        logic     ld_err;
        logic     ld_sum;
        logic     ld_inc;
        logic     ld_out;
    } t_seq_ctrl;

    function automatic logic signed [DataW-1:0] sat32(input logic signed [AccW-1:0] v);
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &v[AccW-1:DataW-1];
        hi_zeros = ~|v[AccW-1:DataW-1];
        if (hi_ones || hi_zeros) begin
            return v[DataW-1:0];
        end else if (v[AccW-1]) begin
            return {1'b1, {(DataW-1){1'b0}}};
        end else begin
            return {1'b0, {(DataW-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [SumW-1:0] sat48(input logic signed [SumW:0] v);
        if (v[SumW] == v[SumW-1]) begin
            return v[SumW-1:0];
        end else if (v[SumW]) begin
            return {1'b1, {(SumW-1){1'b0}}};
        end else begin
            return {1'b0, {(SumW-1){1'b1}}};
        end
    endfunction

endpackage

// File: design/fpsc_mul.sv
// Shared signed multiplier with a registered product and its accumulate tag.
module fpsc_mul (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic signed [fpsc_pkg::OpW-1:0]        i_a,
    input  logic signed [fpsc_pkg::OpW-1:0]        i_b,
    input  fpsc_pkg::t_tag                         i_tag,
    output logic signed [fpsc_pkg::ProdW-1:0]      o_prod,
    output fpsc_pkg::t_tag                         o_tag
);

    logic signed [fpsc_pkg::ProdW-1:0] r_prod;
    fpsc_pkg::t_tag                    r_tag;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= fpsc_pkg::TAG_NONE;
        end else begin
            r_tag <= i_tag;
        end
    end

    assign o_prod = r_prod;
    assign o_tag  = r_tag;

endmodule

// File: design/fpsc_seq.sv
// Sequencer that steps one item through the filter, error and PID phases.
module fpsc_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_out_free,
    output logic                  o_ready,
    output fpsc_pkg::t_seq_ctrl   o_ctrl
);

    typedef enum logic [13:0] {
        ST_IDLE = 14'b00000000000001,
        ST_FA   = 14'b00000000000010,
        ST_FB   = 14'b00000000000100,
        ST_FS   = 14'b00000000001000,
        ST_E1   = 14'b00000000010000,
        ST_E2   = 14'b00000000100000,
        ST_E3   = 14'b00000001000000,
        ST_MP   = 14'b00000010000000,
        ST_MIH  = 14'b00000100000000,
        ST_MIL  = 14'b00001000000000,
        ST_MD   = 14'b00010000000000,
        ST_MF   = 14'b00100000000000,
        ST_SAT  = 14'b01000000000000,
        ST_CMD  = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_ctrl          = '0;
        o_ctrl.mul_sel  = fpsc_pkg::SEL_FILT_NEW;
        o_ctrl.tag      = fpsc_pkg::TAG_NONE;
        case (r_state)
            ST_IDLE: begin
                o_ctrl.acc_clr = 1'b1;
                if (i_start) begin
                    n_state = ST_FA;
                end
            end
            ST_FA: begin
                o_ctrl.mul_sel = fpsc_pkg::SEL_FILT_NEW;
                o_ctrl.tag     = fpsc_pkg::TAG_RAW;
                n_state        = ST_FB;
            end
            ST_FB: begin
                o_ctrl.mul_sel = fpsc_pkg::SEL_FILT_OLD;
                o_ctrl.tag     = fpsc_pkg::TAG_RAW;
                n_state        = ST_FS;
            end
            ST_FS: begin
                n_state = ST_E1;
            end
            ST_E1: begin
                o_ctrl.ld_filt = 1'b1;
                o_ctrl.acc_clr = 1'b1;
                n_state        = ST_E2;
            end
            ST_E2: begin
                o_ctrl.ld_err = 1'b1;
                n_state       = ST_E3;
            end
            ST_E3: begin
                o_ctrl.ld_sum = 1'b1;
                n_state       = ST_MP;
            end
            ST_MP: begin
                o_ctrl.mul_sel = fpsc_pkg::SEL_P;
                o_ctrl.tag     = fpsc_pkg::TAG_RND;
                n_state        = ST_MIH;
            end
            ST_MIH: begin
                o_ctrl.mul_sel = fpsc_pkg::SEL_I_HI;
                o_ctrl.tag     = fpsc_pkg::TAG_RAW;
                n_state        = ST_MIL;
            end
            ST_MIL: begin
                o_ctrl.mul_sel = fpsc_pkg::SEL_I_LO;
                o_ctrl.tag     = fpsc_pkg::TAG_RND;
                n_state        = ST_MD;
            end
            ST_MD: begin
                o_ctrl.mul_sel = fpsc_pkg::SEL_D;
                o_ctrl.tag     = fpsc_pkg::TAG_RND;
                n_state        = ST_MF;
            end
            ST_MF: begin
                n_state = ST_SAT;
            end
            ST_SAT: begin
                o_ctrl.ld_inc = 1'b1;
                n_state       = ST_CMD;
            end
            ST_CMD: begin
                // Hold here until the output register has room.
                if (i_out_free) begin
                    o_ctrl.ld_out = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);

endmodule

// File: design/filtered_pid_speed_controller.sv
// Top level: filtered incremental PID speed controller with one shared multiplier.
// An accepted item passes through the filter, error, PID multiply, saturation and command steps
// before its result is loaded into the output register; a new item is taken only back in idle. Six
// multiplies go one by one through the shared multiplier, followed by rounding, saturation and accumulate steps.
// A result waiting in the output register holds the sequencer in its last step.
// Synchronous active-low reset clears the controller state and restores the default settings.
module filtered_pid_speed_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // measured_speed [31:0], target_speed [63:32], applied_force [95:64]
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // force_command [31:0], force_increment [63:32], filtered_speed [95:64]
    output logic [95:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [fpsc_pkg::IdxW-1:0]  i_cfg_idx,
    input  logic [fpsc_pkg::DataW-1:0] i_cfg_data
);

    localparam int unsigned DW = fpsc_pkg::DataW;

    fpsc_pkg::t_seq_ctrl ctrl;
    logic                seq_ready;
    logic                accept;
    logic                out_free;

    logic signed [DW-1:0]               r_gain_p;
    logic signed [DW-1:0]               r_gain_i;
    logic signed [DW-1:0]               r_gain_d;
    logic [fpsc_pkg::CoefW-1:0]         r_coef;

    logic signed [DW-1:0]               r_meas;
    logic signed [DW-1:0]               r_target;
    logic signed [DW-1:0]               r_applied;

    logic signed [DW-1:0]               r_filt;
    logic signed [fpsc_pkg::SumW-1:0]   r_sum;
    logic signed [DW-1:0]               r_last_err;
    logic signed [DW-1:0]               r_err;
    logic signed [fpsc_pkg::OpW-1:0]    r_diff;
    logic signed [DW-1:0]               r_inc;
    logic signed [fpsc_pkg::AccW-1:0]   r_acc;

    logic                               r_out_valid;
    logic [DW-1:0]                      r_out_cmd;
    logic [DW-1:0]                      r_out_inc;
    logic [DW-1:0]                      r_out_filt;

    logic                               gains_zero;
    logic signed [DW-1:0]               kp_eff;
    logic [fpsc_pkg::CoefW-1:0]         a_eff;
    logic [fpsc_pkg::CoefW-1:0]         a_rest;
    logic signed [fpsc_pkg::OpW-1:0]    mul_a;
    logic signed [fpsc_pkg::OpW-1:0]    mul_b;
    logic signed [fpsc_pkg::ProdW-1:0]  mul_prod;
    fpsc_pkg::t_tag                     mul_tag;
    logic signed [fpsc_pkg::AccW-1:0]   prod_rnd;
    logic signed [fpsc_pkg::AccW-1:0]   acc_term;
    logic signed [fpsc_pkg::AccW-1:0]   filt_rnd;
    logic signed [fpsc_pkg::AccW-1:0]   err_full;
    logic signed [fpsc_pkg::SumW:0]     sum_full;
    logic signed [fpsc_pkg::AccW-1:0]   cmd_full;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    fpsc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_out_free (out_free),
        .o_ready    (seq_ready),
        .o_ctrl     (ctrl)
    );

    assign s_axis_tready = seq_ready && i_rst_n;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= fpsc_pkg::GainPReset;
            r_gain_i <= fpsc_pkg::GainIReset;
            r_gain_d <= fpsc_pkg::GainDReset;
            r_coef   <= fpsc_pkg::CoefReset;
        end else if (i_cfg_we) begin
            case (fpsc_pkg::t_reg_idx'(i_cfg_idx))
                fpsc_pkg::REG_GAIN_P: r_gain_p <= i_cfg_data;
                fpsc_pkg::REG_GAIN_I: r_gain_i <= i_cfg_data;
                fpsc_pkg::REG_GAIN_D: r_gain_d <= i_cfg_data;
                fpsc_pkg::REG_COEF:   r_coef   <= i_cfg_data[fpsc_pkg::CoefW-1:0];
                default: begin
                end
            endcase
        end
    end

    // When every gain is zero the default proportional gain takes over for the item.
    assign gains_zero = (r_gain_p == '0) && (r_gain_i == '0) && (r_gain_d == '0);
    assign kp_eff     = gains_zero ? fpsc_pkg::DefaultKp : r_gain_p;
    assign a_eff      = (r_coef > fpsc_pkg::CoefOne) ? fpsc_pkg::CoefOne : r_coef;
    assign a_rest     = fpsc_pkg::CoefOne - a_eff;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.mul_sel)
            fpsc_pkg::SEL_FILT_NEW: begin
                mul_a = signed'({{(fpsc_pkg::OpW - fpsc_pkg::CoefW){1'b0}}, a_rest});
                mul_b = fpsc_pkg::OpW'(r_meas);
            end
            fpsc_pkg::SEL_FILT_OLD: begin
                mul_a = signed'({{(fpsc_pkg::OpW - fpsc_pkg::CoefW){1'b0}}, a_eff});
                mul_b = fpsc_pkg::OpW'(r_filt);
            end
            fpsc_pkg::SEL_P: begin
                mul_a = fpsc_pkg::OpW'(kp_eff);
                mul_b = fpsc_pkg::OpW'(r_err);
            end
            fpsc_pkg::SEL_I_HI: begin
                // Integer part of the accumulated error, floor of sum / 65536.
                mul_a = fpsc_pkg::OpW'(r_gain_i);
                mul_b = fpsc_pkg::OpW'(signed'(r_sum[fpsc_pkg::SumW-1:16]));
            end
            fpsc_pkg::SEL_I_LO: begin
                mul_a = fpsc_pkg::OpW'(r_gain_i);
                mul_b = signed'({{(fpsc_pkg::OpW - 16){1'b0}}, r_sum[15:0]});
            end
            fpsc_pkg::SEL_D: begin
                mul_a = fpsc_pkg::OpW'(r_gain_d);
                mul_b = r_diff;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    fpsc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_tag   (ctrl.tag),
        .o_prod  (mul_prod),
        .o_tag   (mul_tag)
    );

    assign prod_rnd = (mul_prod + fpsc_pkg::RoundHalf) >>> 16;

    always_comb begin
        case (mul_tag)
            fpsc_pkg::TAG_RAW:  acc_term = mul_prod;
            fpsc_pkg::TAG_RND:  acc_term = prod_rnd;
            fpsc_pkg::TAG_NONE: acc_term = '0;
            default:            acc_term = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.acc_clr) begin
            r_acc <= '0;
        end else begin
            r_acc <= r_acc + acc_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_meas    <= s_axis_tdata[DW-1:0];
            r_target  <= s_axis_tdata[2*DW-1:DW];
            r_applied <= s_axis_tdata[3*DW-1:2*DW];
        end
    end

    assign filt_rnd = (r_acc + fpsc_pkg::RoundHalf) >>> 16;
    assign err_full = fpsc_pkg::AccW'(r_target) - fpsc_pkg::AccW'(r_filt);
    assign sum_full = (fpsc_pkg::SumW + 1)'(r_sum) + (fpsc_pkg::SumW + 1)'(r_err);
    assign cmd_full = fpsc_pkg::AccW'(r_applied) + fpsc_pkg::AccW'(r_inc);

    // Controller state carried from item to item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt     <= '0;
            r_sum      <= '0;
            r_last_err <= '0;
        end else begin
            if (ctrl.ld_filt) begin
                r_filt <= fpsc_pkg::sat32(filt_rnd);
            end
            if (ctrl.ld_sum) begin
                r_sum      <= fpsc_pkg::sat48(sum_full);
                r_last_err <= r_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.ld_err) begin
            r_err <= fpsc_pkg::sat32(err_full);
        end
        if (ctrl.ld_sum) begin
            r_diff <= fpsc_pkg::OpW'(r_err) - fpsc_pkg::OpW'(r_last_err);
        end
        if (ctrl.ld_inc) begin
            r_inc <= fpsc_pkg::sat32(r_acc);
        end
        if (ctrl.ld_out) begin
            r_out_cmd  <= fpsc_pkg::sat32(cmd_full);
            r_out_inc  <= r_inc;
            r_out_filt <= r_filt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_filt, r_out_inc, r_out_cmd};

endmodule

// File: bench/tb_filtered_pid_speed_controller.sv
`timescale 1ns / 1ps
// Stream testbench for the filtered PID speed controller with an in-bench fixed-point predictor.
module tb_filtered_pid_speed_controller;

    localparam int unsigned CycleLimit  = 400000;
    localparam int unsigned NumSegments = 12;
    localparam int unsigned SegItems    = 128;
    localparam logic [31:0] QMax = 32'h7FFF_FFFF;
    localparam logic [31:0] QMin = 32'h8000_0000;
    localparam longint I32Max = 64'sd2147483647;
    localparam longint I32Min = -64'sd2147483648;
    localparam longint SumMax = (64'sd1 <<< 47) - 1;
    localparam longint SumMin = -(64'sd1 <<< 47);

    // Highest field first, matching the tdata layout of the output stream.
    typedef struct packed {
        logic [31:0] filtered;
        logic [31:0] increment;
        logic [31:0] command;
    } t_force_result;

    class t_force_scoreboard;
        longint        kp_reg, ki_reg, kd_reg;
        int unsigned   coef_reg;
        longint        filt_mem, err_sum, err_last;
        t_force_result pending_cmds[$];
        int            n_ticks, n_checked, n_errors, n_writes;

        function new();
            kp_reg   = fpsc_pkg::GainPReset;
            ki_reg   = fpsc_pkg::GainIReset;
            kd_reg   = fpsc_pkg::GainDReset;
            coef_reg = fpsc_pkg::CoefReset;
            filt_mem = 0;
            err_sum  = 0;
            err_last = 0;
            n_ticks  = 0;
            n_checked = 0;
            n_errors = 0;
            n_writes = 0;
        endfunction

        function void write_reg(fpsc_pkg::t_reg_idx idx, logic [31:0] v);
            n_writes++;
            case (idx)
                fpsc_pkg::REG_GAIN_P: kp_reg = $signed(v);
                fpsc_pkg::REG_GAIN_I: ki_reg = $signed(v);
                fpsc_pkg::REG_GAIN_D: kd_reg = $signed(v);
                fpsc_pkg::REG_COEF:   coef_reg = v[fpsc_pkg::CoefW-1:0];
                default: ;
            endcase
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        // Q.16 rounding, half toward plus infinity.
        function longint round_q16(longint v);
            return (v + 32768) >>> 16;
        endfunction

        function void note_tick(logic [95:0] d);
            longint meas, tgt, appl, a, kp, ki, kd;
            longint filt, err, sum_hi, sum_lo, p_term, i_term, d_term, inc, cmd;
            t_force_result r;
            meas = $signed(d[31:0]);
            tgt  = $signed(d[63:32]);
            appl = $signed(d[95:64]);
            a  = (coef_reg > fpsc_pkg::CoefOne) ? fpsc_pkg::CoefOne : coef_reg;
            kp = kp_reg;
            ki = ki_reg;
            kd = kd_reg;
            if (kp == 0 && ki == 0 && kd == 0) kp = fpsc_pkg::DefaultKp;

            filt = clip(round_q16((65536 - a) * meas + a * filt_mem), I32Min, I32Max);
            filt_mem = filt;
            err = clip(tgt - filt, I32Min, I32Max);
            err_sum = clip(err_sum + err, SumMin, SumMax);

            // The integral product is split at bit 16 so that it fits in 64 bits.
            sum_hi = err_sum >>> 16;
            sum_lo = err_sum - (sum_hi <<< 16);
            p_term = round_q16(kp * err);
            i_term = ki * sum_hi + round_q16(ki * sum_lo);
            d_term = round_q16(kd * (err - err_last));
            inc = clip(p_term + i_term + d_term, I32Min, I32Max);
            err_last = err;
            cmd = clip(appl + inc, I32Min, I32Max);

            r.command   = cmd[31:0];
            r.increment = inc[31:0];
            r.filtered  = filt[31:0];
            pending_cmds.push_back(r);
            n_ticks++;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                n_errors++;
                $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            end
        endfunction

        function void check_command(logic [95:0] d);
            t_force_result want, got;
            got = d;
            if (pending_cmds.size() == 0) begin
                n_errors++;
                $error("result with no item pending: %h", d);
                return;
            end
            want = pending_cmds.pop_front();
            n_checked++;
            compare_field("force_command", want.command, got.command);
            compare_field("force_increment", want.increment, got.increment);
            compare_field("filtered_speed", want.filtered, got.filtered);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [fpsc_pkg::IdxW-1:0]  i_cfg_idx = '0;
    logic [fpsc_pkg::DataW-1:0] i_cfg_data = '0;

    t_force_scoreboard sb;
    int unsigned cycle_count = 0;
    int unsigned src_idle_pct = 34;
    int unsigned sink_idle_pct = 64;
    int windup_left = 0;
    bit windup_up = 1'b0;

    filtered_pid_speed_controller u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("tb_filtered_pid_speed_controller: FAIL");
            $finish;
        end
    end

    // Output side: check every accepted item, then pick the next ready at random.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_command(m_axis_tdata);
        end
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    function automatic logic [95:0] pack_tick(logic [31:0] meas, logic [31:0] tgt,
                                              logic [31:0] appl);
        return {appl, tgt, meas};
    endfunction

    function automatic logic [31:0] pick_edge();
        case ($urandom_range(4))
            0: return QMax;
            1: return QMin;
            2: return 32'd0;
            3: return 32'hFFFF_FFFF;
            default: return 32'd1;
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return QMax;
            2: return QMin;
            3: return $urandom;
            default: return 32'(int'($urandom_range(262144)) - 131072);
        endcase
    endfunction

    // Coefficient word; the bits above the register width are sometimes filled with noise.
    function automatic logic [31:0] pick_coef();
        logic [fpsc_pkg::CoefW-1:0] c;
        logic [31-fpsc_pkg::CoefW:0] junk;
        case ($urandom_range(4))
            0: c = '0;
            1: c = fpsc_pkg::CoefOne;
            2: c = fpsc_pkg::CoefW'($urandom_range(65536));
            3: c = fpsc_pkg::CoefW'($urandom_range(131071, 65537));
            default: c = fpsc_pkg::CoefW'($urandom_range(65535, 55000));
        endcase
        junk = $urandom_range(1) ? (32 - fpsc_pkg::CoefW)'($urandom) : '0;
        return {junk, c};
    endfunction

    // Mostly plausible speeds, with windup runs that hold the error at one extreme.
    function automatic logic [95:0] make_tick();
        logic [31:0] meas, tgt, appl;
        int unsigned r;
        if (windup_left == 0 && $urandom_range(99) < 2) begin
            windup_left = $urandom_range(200, 20);
            windup_up = 1'($urandom_range(1));
        end
        if (windup_left > 0) begin
            windup_left--;
            meas = windup_up ? QMin : QMax;
            tgt  = windup_up ? QMax : QMin;
            appl = int'($urandom) >>> $urandom_range(24, 8);
        end else begin
            r = $urandom_range(99);
            if (r < 50) begin
                meas = 32'(int'($urandom_range(1310720)) - 655360);
                tgt  = 32'(int'($urandom_range(1310720)) - 655360);
                appl = 32'(int'($urandom_range(13107200)) - 6553600);
            end else if (r < 85) begin
                meas = int'($urandom) >>> $urandom_range(24);
                tgt  = int'($urandom) >>> $urandom_range(24);
                appl = int'($urandom) >>> $urandom_range(24);
            end else begin
                meas = pick_edge();
                tgt  = pick_edge();
                appl = pick_edge();
            end
        end
        return pack_tick(meas, tgt, appl);
    endfunction

    task automatic send_item(input logic [95:0] d);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_tick(d);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_cmds.size() != 0);
    endtask

    task automatic put_reg(input fpsc_pkg::t_reg_idx idx, input logic [31:0] v);
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.write_reg(idx, v);
    endtask

    task automatic apply_config(input logic [31:0] kp, input logic [31:0] ki,
                                input logic [31:0] kd, input logic [31:0] coef);
        wait_idle();
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        put_reg(fpsc_pkg::REG_GAIN_P, kp);
        put_reg(fpsc_pkg::REG_GAIN_I, ki);
        put_reg(fpsc_pkg::REG_GAIN_D, kd);
        put_reg(fpsc_pkg::REG_COEF, coef);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default gains and coefficient straight out of reset.
        send_item(pack_tick(32'd0, 32'd0, 32'd0));
        send_item(pack_tick(QMax, QMax, QMax));
        send_item(pack_tick(QMin, QMin, QMin));
        send_item(pack_tick(QMax, QMin, QMin));

        // Largest gains with no filtering: the error, increment and command stages saturate.
        apply_config(QMax, QMax, QMax, 32'd0);
        send_item(pack_tick(QMin, QMax, QMax));
        send_item(pack_tick(QMax, QMin, QMin));
        send_item(pack_tick(32'd0, 32'd0, 32'd0));

        // Most negative gains; a coefficient above one freezes the filter.
        apply_config(QMin, QMin, QMin, 32'd65537);
        send_item(pack_tick(QMax, QMin, QMax));
        send_item(pack_tick(QMin, QMax, QMin));
        send_item(pack_tick(32'hFFFF_FFFF, 32'd1, 32'd0));

        // All gains zero, so the default proportional gain takes over.
        apply_config(32'd0, 32'd0, 32'd0, 32'd131071);
        send_item(pack_tick(32'd12345, 32'd655360, 32'd100));
        send_item(pack_tick(QMin, QMax, 32'd0));
        send_item(pack_tick(QMax, QMin, 32'd0));

        // Gains of 1.0, 1 LSB and -1.0 with a half-weight filter exercise half-point rounding.
        apply_config(32'd65536, 32'd1, 32'hFFFF_0000, 32'd32768);
        send_item(pack_tick(32'd1, 32'd0, 32'd0));
        send_item(pack_tick(32'hFFFF_FFFF, 32'd0, 32'd0));
        send_item(pack_tick(32'd3, 32'd0, 32'd0));
        send_item(pack_tick(32'd65536, 32'd131072, 32'd65536));
        send_item(pack_tick(32'hFFF6_0000, 32'd655360, 32'hFFFF_0000));

        for (int seg = 0; seg < NumSegments; seg++) begin
            if (seg == NumSegments / 3) begin
                src_idle_pct  = 64;
                sink_idle_pct = 34;
            end else if (seg == 2 * NumSegments / 3) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            if (seg == 1) begin
                apply_config(32'd0, 32'd0, 32'd0, pick_coef());
            end else begin
                apply_config(pick_gain(), pick_gain(), pick_gain(), pick_coef());
            end
            for (int n = 0; n < SegItems; n++) begin
                if ($urandom_range(149) == 0) wait_idle();
                send_item(make_tick());
            end
        end

        wait_idle();
        repeat (30) @(posedge i_clk);

        $display("Run covered %0d ticks and %0d checked results over %0d register writes,",
                 sb.n_ticks, sb.n_checked, sb.n_writes);
        $display("including saturation, default-gain, frozen-filter and windup sequences.");
        if (sb.n_errors == 0 && sb.pending_cmds.size() == 0) begin
            $display("tb_filtered_pid_speed_controller: PASS");
        end else begin
            $display("tb_filtered_pid_speed_controller: FAIL");
        end
        $finish;
    end

endmodule
